/* sv/tcon_pkg.sv */
// shared types and constants of the text console with key buffer
package tcon_pkg;

  // request kinds on the command port
  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_PRINT = 2'd1,
    REQ_TAKE  = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  // scan codes and characters with a meaning of their own
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_RELEASE   = 8'h81;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // attribute byte after reset
  localparam logic [7:0] ATTR_RESET   = 8'h0C;

  // key ring commands from the sequencer
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       drop;
    logic [7:0] push_data;
  } ring_ctrl_t;

  // key ring status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

/* sv/tcon_screen_ram.sv */
// screen cell memory, one write port and one registered read port
module tcon_screen_ram #(
  parameter int Depth = 2000,
  parameter int Aw    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tcon_key_ring.sv */
// keyboard ring buffer with head and tail pointers, one slot kept free
module tcon_key_ring import tcon_pkg::*; #(
  parameter int Depth = 256,
  parameter int Pw    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_ctrl_t ctrl_i,
  output ring_stat_t stat_o,
  output logic [7:0] rdata_o
);

  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;
  logic [Pw-1:0] head_q, head_d;
  logic [Pw-1:0] tail_q, tail_d;
  logic [Pw-1:0] head_inc, tail_inc, tail_dec;

  // modular pointer steps
  assign head_inc = (head_q == Pw'(Depth - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == Pw'(Depth - 1)) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? Pw'(Depth - 1) : tail_q - 1'b1;

  assign stat_o.empty = (head_q == tail_q);
  assign stat_o.full  = (tail_inc == head_q);

  // pointer updates
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.push) begin
      tail_d = tail_inc;
    end else if (ctrl_i.drop) begin
      tail_d = tail_dec;
    end
    if (ctrl_i.pop) begin
      head_d = head_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // storage, read at the head every cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= ctrl_i.push_data;
    end
    rdata_q <= mem[head_q];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/text_console_with_key_buffer_unit.sv */
// text console with key ring buffer: top level and request sequencer
//
//  channel   ports                                    handshake
//  command   req_type_i scan_code_i char_code_i       start / busy
//            last_char_i cell_index_i
//  result    shown_row_o shown_col_o key_valid_o      done_o, one cycle
//            key_out_o key_stored_o cell_value_o
//  attribute attr_wdata_i                             attr_we_i
//
//  key event and print: result in the cycle after start, ready again at once
//  take key and read cell: pass through S_READ, which waits for the registered memory read
//  a key or print that scrolls: the single sweep counter moves the screen
//    memory up one row, one cell per cycle
//  after reset the sweep clears the screen memory while busy is high
//  results cannot be stalled; attribute writes are taken in every cycle
module text_console_with_key_buffer_unit import tcon_pkg::*; #(
  parameter int KEY_BUFFER_DEPTH = 256,
  parameter int SCREEN_COLUMNS   = 80,
  parameter int SCREEN_ROWS      = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  scan_code_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  input  logic [10:0] cell_index_i,
  input  logic        attr_we_i,
  input  logic [7:0]  attr_wdata_i,
  output logic        done_o,
  output logic [4:0]  shown_row_o,
  output logic [6:0]  shown_col_o,
  output logic        key_valid_o,
  output logic [7:0]  key_out_o,
  output logic        key_stored_o,
  output logic [15:0] cell_value_o
);

  localparam int CellCount = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int Aw = $clog2(CellCount);
  localparam int Rw = $clog2(SCREEN_ROWS);
  localparam int Cw = $clog2(SCREEN_COLUMNS);
  localparam int Sw = $clog2(CellCount + SCREEN_COLUMNS + 1);
  localparam int Pw = $clog2(KEY_BUFFER_DEPTH);

  // sequencer states
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [Sw-1:0] sweep_q, sweep_d;
  logic [Rw-1:0] row_q, row_d;
  logic [Cw-1:0] col_q, col_d;
  logic [Aw-1:0] base_q, base_d;
  logic [Rw-1:0] shown_row_q, shown_row_d;
  logic [Cw-1:0] shown_col_q, shown_col_d;
  logic [7:0]    attr_q;
  logic          done_q, done_d;
  logic          key_valid_q, key_valid_d;
  logic          key_stored_q, key_stored_d;
  logic [7:0]    key_out_q, key_out_d;
  logic [15:0]   cell_value_q, cell_value_d;
  logic          rd_cell_q, rd_cell_d;

  req_type_e     req;
  logic          acc;
  logic          is_bs, is_ent, is_other, bs_do, is_pnl, put, nl, scroll, last_col;
  logic          show;
  logic [Cw-1:0] col_dec, col_sel;
  logic [Sw-1:0] sweep_inc, sweep_back;
  logic [31:0]   idx_ext;

  logic          scr_we;
  logic [Aw-1:0] scr_waddr, scr_raddr;
  logic [15:0]   scr_wdata, scr_rdata;

  ring_ctrl_t    ring_ctrl;
  ring_stat_t    ring_stat;
  logic [7:0]    ring_rdata;

  logic [Rw+4:0] shown_row_ext;
  logic [Cw+6:0] shown_col_ext;

  assign busy = (state_q != S_IDLE);
  assign acc  = start && !busy;
  assign req  = req_type_e'(req_type_i);

  // request decode
  assign is_bs    = (req == REQ_KEY) && (scan_code_i == SC_BACKSPACE);
  assign is_ent   = (req == REQ_KEY) && (scan_code_i == SC_ENTER);
  assign is_other = (req == REQ_KEY) && !is_bs && !is_ent
                    && (scan_code_i < SC_RELEASE) && (char_code_i != 8'h00);
  assign bs_do    = is_bs && !ring_stat.empty && (col_q != '0);
  assign is_pnl   = (req == REQ_PRINT) && (char_code_i == CH_NEWLINE);
  assign put      = is_other || ((req == REQ_PRINT) && !is_pnl);
  assign last_col = (col_q == Cw'(SCREEN_COLUMNS - 1));
  assign nl       = is_ent || is_pnl || (put && last_col);
  assign scroll   = nl && (row_q == Rw'(SCREEN_ROWS - 1));
  assign show     = (req == REQ_KEY) || ((req == REQ_PRINT) && last_char_i);
  assign col_dec  = col_q - 1'b1;
  assign col_sel  = bs_do ? col_dec : col_q;

  // shared sweep counter for clearing and scrolling
  assign sweep_inc  = sweep_q + 1'b1;
  assign sweep_back = sweep_q - Sw'(SCREEN_COLUMNS + 1);

  // key ring requests
  always_comb begin
    ring_ctrl.push      = acc && (is_ent || is_other) && !ring_stat.full;
    ring_ctrl.pop       = acc && (req == REQ_TAKE) && !ring_stat.empty;
    ring_ctrl.drop      = acc && bs_do;
    ring_ctrl.push_data = is_ent ? CH_NEWLINE : char_code_i;
  end

  // screen memory ports
  assign idx_ext   = 32'(cell_index_i);
  assign scr_raddr = (state_q == S_SCROLL) ? sweep_q[Aw-1:0] : idx_ext[Aw-1:0];

  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = base_q + Aw'(col_sel);
    scr_wdata = {attr_q, put ? char_code_i : CH_SPACE};
    case (state_q)
      S_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = sweep_q[Aw-1:0];
        scr_wdata = '0;
      end
      S_IDLE: begin
        scr_we = acc && (put || bs_do);
      end
      S_SCROLL: begin
        scr_we    = (sweep_q != Sw'(SCREEN_COLUMNS));
        scr_waddr = sweep_back[Aw-1:0];
        scr_wdata = (sweep_q <= Sw'(CellCount)) ? scr_rdata : {attr_q, CH_SPACE};
      end
      default: begin
        scr_we = 1'b0;
      end
    endcase
  end

  // sequencer and cursor
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    row_d        = row_q;
    col_d        = col_q;
    base_d       = base_q;
    shown_row_d  = shown_row_q;
    shown_col_d  = shown_col_q;
    done_d       = 1'b0;
    key_valid_d  = key_valid_q;
    key_stored_d = key_stored_q;
    key_out_d    = key_out_q;
    cell_value_d = cell_value_q;
    rd_cell_d    = rd_cell_q;
    case (state_q)
      S_CLEAR: begin
        sweep_d = sweep_inc;
        if (sweep_q == Sw'(CellCount - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          // cursor after this request
          if (nl) begin
            col_d = '0;
            if (!scroll) begin
              row_d  = row_q + 1'b1;
              base_d = base_q + Aw'(SCREEN_COLUMNS);
            end
          end else if (put) begin
            col_d = col_q + 1'b1;
          end else if (bs_do) begin
            col_d = col_dec;
          end
          if (show) begin
            shown_row_d = row_d;
            shown_col_d = col_d;
          end
          // result fields known now
          key_valid_d  = ring_ctrl.pop;
          key_stored_d = ring_ctrl.push;
          key_out_d    = 8'h00;
          cell_value_d = '0;
          rd_cell_d    = (req == REQ_READ) && (idx_ext < 32'(CellCount));
          // next step
          if (scroll) begin
            state_d = S_SCROLL;
            sweep_d = Sw'(SCREEN_COLUMNS);
          end else if ((req == REQ_TAKE) || (req == REQ_READ)) begin
            state_d = S_READ;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        sweep_d = sweep_inc;
        if (sweep_q == Sw'(CellCount + SCREEN_COLUMNS)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_READ: begin
        if (key_valid_q) begin
          key_out_d = ring_rdata;
        end
        if (rd_cell_q) begin
          cell_value_d = scr_rdata;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      shown_row_q <= '0;
      shown_col_q <= '0;
      attr_q      <= ATTR_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      row_q       <= row_d;
      col_q       <= col_d;
      base_q      <= base_d;
      shown_row_q <= shown_row_d;
      shown_col_q <= shown_col_d;
      done_q      <= done_d;
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    key_valid_q  <= key_valid_d;
    key_stored_q <= key_stored_d;
    key_out_q    <= key_out_d;
    cell_value_q <= cell_value_d;
    rd_cell_q    <= rd_cell_d;
  end

  tcon_screen_ram #(
    .Depth(CellCount),
    .Aw   (Aw)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(scr_wdata),
    .raddr_i(scr_raddr),
    .rdata_o(scr_rdata)
  );

  tcon_key_ring #(
    .Depth(KEY_BUFFER_DEPTH),
    .Pw   (Pw)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .stat_o (ring_stat),
    .rdata_o(ring_rdata)
  );

  // outputs, cursor truncated to the port widths
  assign shown_row_ext = (Rw + 5)'(shown_row_q);
  assign shown_col_ext = (Cw + 7)'(shown_col_q);
  assign shown_row_o   = shown_row_ext[4:0];
  assign shown_col_o   = shown_col_ext[6:0];
  assign done_o        = done_q;
  assign key_valid_o   = key_valid_q;
  assign key_out_o     = key_out_q;
  assign key_stored_o  = key_stored_q;
  assign cell_value_o  = cell_value_q;

endmodule

/* sv/tcon_checker.sv */
// port level checks of the text console, bound to the top level
module tcon_checker import tcon_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type_i,
  input logic       done_o,
  input logic       key_valid_o,
  input logic [7:0] key_out_o,
  input logic       key_stored_o
);

  // a result is never shown while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // take key and read cell answer after the registered memory read, not at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_TAKE || req_type_i == REQ_READ))
      |=> !done_o ##1 done_o)
    else $error("read request not answered in two cycles");

  // key event and print answer at once or start a scroll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_KEY || req_type_i == REQ_PRINT))
      |=> (done_o || busy))
    else $error("key or print request neither answered nor scrolling");

  // a result without a popped key, such as an empty take key, returns a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !key_valid_o) |-> (key_out_o == 8'h00))
    else $error("key data without a popped key");

  // a request cannot both pop and store a key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(key_valid_o && key_stored_o))
    else $error("pop and store in one result");

endmodule

bind text_console_with_key_buffer_unit tcon_checker u_tcon_checker (.*);
